### hw/rtl/aabb_pair_collision_sweep_assert.svh
// ----------------------------------------------------------------------------
// aabb pair collision sweep assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef AABB_PAIR_COLLISION_SWEEP_ASSERT_SVH
`define AABB_PAIR_COLLISION_SWEEP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AABB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AABB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared widths, codes and defaults for the box pair collision sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabb_pkg;

  // parameter defaults
  localparam int MAX_OBJECTS_DEF = 8;
  localparam int COORD_BITS_DEF  = 16;

  // fixed field widths
  localparam int TAG_W      = 8;
  localparam int FIELD_W    = 16;
  localparam int INDEX_W    = 3;
  localparam int DIR_W      = 2;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  // saturation point of the collision counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // direction codes, side of box i relative to box j
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_TOP    = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 2'd3;

  // shared adder operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD    = 2'd0;
  localparam alu_op_t ALU_SUB    = 2'd1;
  localparam alu_op_t ALU_SHRINK = 2'd2;

endpackage

### hw/rtl/aabb_store.sv
// ----------------------------------------------------------------------------
// aabb_store
// Object record memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_store import aabb_pkg::*; #(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(MAX_OBJECTS)-1:0]       wr_addr,
  input  logic [TAG_W+4*COORD_BITS-1:0]        wr_rec,
  input  logic [$clog2(MAX_OBJECTS)-1:0]       rd_addr_a,
  input  logic [$clog2(MAX_OBJECTS)-1:0]       rd_addr_b,
  output logic [TAG_W+4*COORD_BITS-1:0]        rd_rec_a,
  output logic [TAG_W+4*COORD_BITS-1:0]        rd_rec_b
);

  localparam int REC_W = TAG_W + 4 * COORD_BITS;

  logic [REC_W-1:0] mem_r [MAX_OBJECTS];
  logic [REC_W-1:0] rd_a_r;
  logic [REC_W-1:0] rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_rec;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_rec_a = rd_a_r;
  assign rd_rec_b = rd_b_r;

endmodule

### hw/rtl/aabb_alu.sv
// ----------------------------------------------------------------------------
// aabb_alu
// Shared adder: add, subtract, and shrink (a minus twice the magnitude of b).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_alu import aabb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  alu_op_t                 op,
  input  logic [COORD_BITS+2:0]   opnd_a,
  input  logic [COORD_BITS+2:0]   opnd_b,
  output logic [COORD_BITS+2:0]   result
);

  localparam int W = COORD_BITS + 3;

  logic [W-1:0] b_sel;
  logic         sub;

  // operand select and carry in
  always_comb begin
    unique case (op)
      ALU_ADD: begin
        b_sel = opnd_b;
        sub   = 1'b0;
      end
      ALU_SUB: begin
        b_sel = opnd_b;
        sub   = 1'b1;
      end
      ALU_SHRINK: begin
        // doubled b, added when b is negative, subtracted otherwise
        b_sel = {opnd_b[W-2:0], 1'b0};
        sub   = ~opnd_b[W-1];
      end
      default: begin
        b_sel = '0;
        sub   = 1'b0;
      end
    endcase
  end

  assign result = opnd_a + (sub ? ~b_sel : b_sel) + W'(sub);

endmodule

### hw/rtl/aabb_pair_collision_sweep.sv
// ----------------------------------------------------------------------------
// aabb_pair_collision_sweep
// Loads boxes, then sweeps all pairs with different tags for overlap.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser        | tlast
//  in_     | in  | tag, x, y, width, height (72 bits) | -            | last_object
//  out_    | out | indices, tags, dir, count (32 b)   | is_collision | last_result
//
//  loading accepts one box per cycle; boxes past MAX_OBJECTS are dropped
//  the sweep runs through one shared adder; each pair takes fetch and tag check,
//  then, when tags differ, 3 to 7 adder steps and an emit on a hit, then advance
//  the run closes with an end marker; in_tready is low from the last box on
//  until the end marker has gone into the output register
//  a stalled output holds the sequencer in its emit or end step; reset is synchronous
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_pair_collision_sweep import aabb_pkg::*; #(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tag_id[7:0], center_x[23:8], center_y[39:24], box_width[55:40],
  // box_height[71:56]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // first_index[2:0], second_index[5:3], first_tag[13:6], second_tag[21:14],
  // direction[23:22], collision_count[28:24], zero[31:29]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // is_collision[0]
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int IDX_W = $clog2(MAX_OBJECTS);
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam int CW    = COORD_BITS;
  localparam int W     = COORD_BITS + 3;
  localparam int REC_W = TAG_W + 4 * COORD_BITS;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_FETCH = 4'd1;
  localparam logic [3:0] ST_TAG   = 4'd2;
  localparam logic [3:0] ST_DX    = 4'd3;
  localparam logic [3:0] ST_SW    = 4'd4;
  localparam logic [3:0] ST_OX    = 4'd5;
  localparam logic [3:0] ST_DY    = 4'd6;
  localparam logic [3:0] ST_SH    = 4'd7;
  localparam logic [3:0] ST_OY    = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;
  localparam logic [3:0] ST_NEXT  = 4'd11;
  localparam logic [3:0] ST_FIN   = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   obj_cnt_r, obj_cnt_nxt;
  logic [COUNT_W-1:0] found_r, found_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;

  logic [W-1:0]       dx_r, dx_nxt;
  logic [W-1:0]       dy_r, dy_nxt;
  logic [W-1:0]       sum_r, sum_nxt;
  logic [W-1:0]       ox_r, ox_nxt;
  logic [W-1:0]       oy_r, oy_nxt;
  logic [DIR_W-1:0]   dir_r, dir_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_last_r;

  logic             in_acc;
  logic             store_we;
  logic [REC_W-1:0] wr_rec;
  logic [REC_W-1:0] rec_a;
  logic [REC_W-1:0] rec_b;
  logic             out_free;
  logic             out_load;

  alu_op_t          alu_op;
  logic [W-1:0]     alu_a;
  logic [W-1:0]     alu_b;
  logic [W-1:0]     alu_res;
  logic             res_pos;

  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] i_inc2;
  logic             dx_pos;
  logic             dy_pos;

  // fields of the two records under test
  logic [TAG_W-1:0] tag_a, tag_b;
  logic [CW-1:0]    x_a, x_b, y_a, y_b, w_a, w_b, h_a, h_b;

  assign tag_a = rec_a[TAG_W-1:0];
  assign tag_b = rec_b[TAG_W-1:0];
  assign x_a   = rec_a[TAG_W +: CW];
  assign x_b   = rec_b[TAG_W +: CW];
  assign y_a   = rec_a[TAG_W + CW +: CW];
  assign y_b   = rec_b[TAG_W + CW +: CW];
  assign w_a   = rec_a[TAG_W + 2 * CW +: CW];
  assign w_b   = rec_b[TAG_W + 2 * CW +: CW];
  assign h_a   = rec_a[TAG_W + 3 * CW +: CW];
  assign h_b   = rec_b[TAG_W + 3 * CW +: CW];

  // input side: coordinates and sizes taken from the low field bits
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign store_we  = in_acc && (obj_cnt_r < CNT_W'(MAX_OBJECTS));
  assign wr_rec    = {CW'(in_tdata[71:56]), CW'(in_tdata[55:40]),
                      CW'(in_tdata[39:24]), CW'(in_tdata[23:8]),
                      in_tdata[7:0]};

  aabb_store #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .COORD_BITS  (COORD_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (store_we),
    .wr_addr   (obj_cnt_r[IDX_W-1:0]),
    .wr_rec    (wr_rec),
    .rd_addr_a (i_r),
    .rd_addr_b (j_r),
    .rd_rec_a  (rec_a),
    .rd_rec_b  (rec_b)
  );

  // operand select for the shared adder
  always_comb begin
    unique case (state_r)
      ST_DX: begin
        alu_op = ALU_SUB;
        alu_a  = {{3{x_a[CW-1]}}, x_a};
        alu_b  = {{3{x_b[CW-1]}}, x_b};
      end
      ST_SW: begin
        alu_op = ALU_ADD;
        alu_a  = {3'b000, w_a};
        alu_b  = {3'b000, w_b};
      end
      ST_OX: begin
        alu_op = ALU_SHRINK;
        alu_a  = sum_r;
        alu_b  = dx_r;
      end
      ST_DY: begin
        alu_op = ALU_SUB;
        alu_a  = {{3{y_a[CW-1]}}, y_a};
        alu_b  = {{3{y_b[CW-1]}}, y_b};
      end
      ST_SH: begin
        alu_op = ALU_ADD;
        alu_a  = {3'b000, h_a};
        alu_b  = {3'b000, h_b};
      end
      ST_OY: begin
        alu_op = ALU_SHRINK;
        alu_a  = sum_r;
        alu_b  = dy_r;
      end
      ST_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = ox_r;
        alu_b  = oy_r;
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  aabb_alu #(
    .COORD_BITS (COORD_BITS)
  ) u_alu (
    .op     (alu_op),
    .opnd_a (alu_a),
    .opnd_b (alu_b),
    .result (alu_res)
  );

  assign res_pos  = !alu_res[W-1] && (alu_res != '0);
  assign dx_pos   = !dx_r[W-1] && (dx_r != '0);
  assign dy_pos   = !dy_r[W-1] && (dy_r != '0);
  assign j_inc    = CNT_W'(j_r) + CNT_W'(1);
  assign i_inc2   = CNT_W'(i_r) + CNT_W'(2);
  assign out_free = !out_valid_r || out_tready;
  assign out_load = out_free && ((state_r == ST_EMIT) || (state_r == ST_FIN));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    obj_cnt_nxt = obj_cnt_r;
    found_nxt   = found_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    sum_nxt     = sum_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    dir_nxt     = dir_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_we) begin
            obj_cnt_nxt = obj_cnt_r + CNT_W'(1);
          end
          if (in_tlast) begin
            found_nxt = '0;
            i_nxt     = '0;
            j_nxt     = IDX_W'(1);
            state_nxt = (obj_cnt_nxt >= CNT_W'(2)) ? ST_FETCH : ST_FIN;
          end
        end
      end
      ST_FETCH: state_nxt = ST_TAG;
      ST_TAG:   state_nxt = (tag_a == tag_b) ? ST_NEXT : ST_DX;
      ST_DX: begin
        dx_nxt    = alu_res;
        state_nxt = ST_SW;
      end
      ST_SW: begin
        sum_nxt   = alu_res;
        state_nxt = ST_OX;
      end
      ST_OX: begin
        ox_nxt    = alu_res;
        state_nxt = res_pos ? ST_DY : ST_NEXT;
      end
      ST_DY: begin
        dy_nxt    = alu_res;
        state_nxt = ST_SH;
      end
      ST_SH: begin
        sum_nxt   = alu_res;
        state_nxt = ST_OY;
      end
      ST_OY: begin
        oy_nxt    = alu_res;
        state_nxt = res_pos ? ST_CMP : ST_NEXT;
      end
      ST_CMP: begin
        // strictly smaller horizontal overlap picks the horizontal side
        if (alu_res[W-1]) begin
          dir_nxt = dx_pos ? DIR_RIGHT : DIR_LEFT;
        end else begin
          dir_nxt = dy_pos ? DIR_TOP : DIR_BOTTOM;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (found_r != COUNT_MAX) begin
            found_nxt = found_r + COUNT_W'(1);
          end
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (j_inc < obj_cnt_r) begin
          j_nxt     = j_inc[IDX_W-1:0];
          state_nxt = ST_FETCH;
        end else if (i_inc2 < obj_cnt_r) begin
          i_nxt     = i_r + IDX_W'(1);
          j_nxt     = i_inc2[IDX_W-1:0];
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          obj_cnt_nxt = '0;
          found_nxt   = '0;
          state_nxt   = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      obj_cnt_r <= '0;
      found_r   <= '0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      obj_cnt_r <= obj_cnt_nxt;
      found_r   <= found_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    sum_r <= sum_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
    dir_r <= dir_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_EMIT) begin
        out_data_r <= {3'b000, COUNT_W'(0), dir_r, tag_b, tag_a,
                       INDEX_W'(j_r), INDEX_W'(i_r)};
        out_user_r <= 1'b1;
        out_last_r <= 1'b0;
      end else begin
        out_data_r <= {3'b000, found_r, DIR_W'(0), TAG_W'(0), TAG_W'(0),
                       INDEX_W'(0), INDEX_W'(0)};
        out_user_r <= 1'b0;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // checks
  `include "aabb_pair_collision_sweep_assert.svh"

  `AABB_ASSERT_NOW(a_pair_order, (state_r != ST_LOAD) && (state_r != ST_FIN), j_r > i_r, "pair indices out of order")
  `AABB_ASSERT_NOW(a_cnt_bound, 1'b1, obj_cnt_r <= CNT_W'(MAX_OBJECTS), "object count beyond capacity")
  `AABB_ASSERT_NOW(a_rec_not_last, out_valid_r && out_user_r, !out_last_r, "collision item marked last")
  `AABB_ASSERT_NEXT(a_busy_after_last, in_acc && in_tlast, !in_tready, "ready right after last box")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box pair collision sweep. Boxes are streamed in
// as sets. Each kept box also goes into a local model of the box store.
// When a set closes, the model works out the collision records and the end
// marker. The output stream is compared record by record, field by field.
// Directed sets come first, then random clustered sets mixed with noise
// boxes. Both sides idle and stall at random, except in the last part.
// ----------------------------------------------------------------------------

module tb_top;
  import aabb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct {
    logic        [TAG_W-1:0]   tag;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic        [FIELD_W-1:0] w;
    logic        [FIELD_W-1:0] h;
  } box_t;

  typedef struct {
    logic               hit;
    logic [INDEX_W-1:0] idx_i;
    logic [INDEX_W-1:0] idx_j;
    logic [TAG_W-1:0]   tag_i;
    logic [TAG_W-1:0]   tag_j;
    logic [DIR_W-1:0]   dir;
    logic [COUNT_W-1:0] count;
    logic               closing;
  } sweep_rec_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // boxes held by the model for the set being loaded
  box_t       held_boxes[MAX_OBJECTS_DEF];
  int         held_n;
  sweep_rec_t pending_recs[$];
  sweep_rec_t want;

  int failures;
  int boxes_sent;
  int gap_pct;
  int stall_pct;
  int ready_hold;
  int quiet_cycles;

  aabb_pair_collision_sweep dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic box_t mk_box(input int tag, input int x, input int y,
                                  input int w, input int h);
    box_t b;
    b.tag = TAG_W'(tag);
    b.x   = FIELD_W'(x);
    b.y   = FIELD_W'(y);
    b.w   = FIELD_W'(w);
    b.h   = FIELD_W'(h);
    return b;
  endfunction

  // overlap test on all held pairs, then the closing marker
  function automatic void sweep_held_boxes();
    sweep_rec_t r;
    int dx, dy, ax, ay, sw, sh;
    int found;
    found = 0;
    for (int i = 0; i < held_n; i++) begin
      for (int j = i + 1; j < held_n; j++) begin
        if (held_boxes[i].tag == held_boxes[j].tag) continue;
        dx = held_boxes[i].x - held_boxes[j].x;
        dy = held_boxes[i].y - held_boxes[j].y;
        ax = 2 * ((dx < 0) ? -dx : dx);
        ay = 2 * ((dy < 0) ? -dy : dy);
        sw = held_boxes[i].w + held_boxes[j].w;
        sh = held_boxes[i].h + held_boxes[j].h;
        if (!(ax < sw && ay < sh)) continue;
        r         = '{default: '0};
        r.hit     = 1'b1;
        r.idx_i   = INDEX_W'(i);
        r.idx_j   = INDEX_W'(j);
        r.tag_i   = held_boxes[i].tag;
        r.tag_j   = held_boxes[j].tag;
        // narrower overlap picks the axis, ties go vertical
        if ((sw - ax) < (sh - ay)) r.dir = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
        else                       r.dir = (dy > 0) ? DIR_TOP : DIR_BOTTOM;
        pending_recs.push_back(r);
        if (found < COUNT_MAX) found++;
      end
    end
    r         = '{default: '0};
    r.count   = COUNT_W'(found);
    r.closing = 1'b1;
    pending_recs.push_back(r);
    held_n = 0;
  endfunction

  // one box onto the input stream; the model follows on acceptance
  task automatic send_box(input box_t b, input bit last);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.h, b.w, b.y, b.x, b.tag};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    boxes_sent++;
    // a full store drops the box, a drop with last still closes the set
    if (held_n < MAX_OBJECTS_DEF) begin
      held_boxes[held_n] = b;
      held_n++;
    end
    if (last) sweep_held_boxes();
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endfunction

  // output side compare against the oldest expected record
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_recs.size() == 0) begin
        $error("result item with no expected record");
        failures++;
      end else begin
        want = pending_recs.pop_front();
        check_field("is_collision", want.hit, out_tuser);
        check_field("first_index", want.idx_i, out_tdata[2:0]);
        check_field("second_index", want.idx_j, out_tdata[5:3]);
        check_field("first_tag", want.tag_i, out_tdata[13:6]);
        check_field("second_tag", want.tag_j, out_tdata[21:14]);
        check_field("direction", want.dir, out_tdata[23:22]);
        check_field("collision_count", want.count, out_tdata[28:24]);
        check_field("last_result", want.closing, out_tlast);
      end
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      ready_hold <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // lone box closing its own set: marker with count zero
  task automatic test_single_box();
    send_box(mk_box(255, -32768, 32767, 65535, 0), 1'b1);
  endtask

  // one pair per direction, identical boxes fall to bottom on the tie
  task automatic test_directions();
    send_box(mk_box(1, 100, 0, 160, 400), 1'b0);
    send_box(mk_box(2, 0, 0, 160, 400), 1'b1);
    send_box(mk_box(1, 0, 0, 160, 400), 1'b0);
    send_box(mk_box(2, 100, 0, 160, 400), 1'b1);
    send_box(mk_box(3, 0, 100, 800, 160), 1'b0);
    send_box(mk_box(4, 0, 0, 800, 160), 1'b1);
    send_box(mk_box(5, -50, -50, 300, 300), 1'b0);
    send_box(mk_box(6, -50, -50, 300, 300), 1'b1);
  endtask

  // equal tags are skipped even when overlapping, edge contact is no hit
  task automatic test_touching_and_equal_tags();
    send_box(mk_box(1, 0, 0, 100, 100), 1'b0);
    send_box(mk_box(1, 0, 0, 100, 100), 1'b0);
    send_box(mk_box(2, 100, 0, 100, 100), 1'b1);
  endtask

  // full-range centres and sizes, including a zero-size box
  task automatic test_coordinate_extremes();
    send_box(mk_box(0, 32767, 32767, 65535, 65535), 1'b0);
    send_box(mk_box(255, -32767, -32767, 65535, 65535), 1'b0);
    send_box(mk_box(128, -32768, -32768, 65535, 65535), 1'b0);
    send_box(mk_box(7, 0, 0, 0, 0), 1'b1);
  endtask

  // eight overlapping boxes, the ninth is dropped but closes the set
  task automatic test_store_full();
    for (int k = 0; k < MAX_OBJECTS_DEF + 1; k++)
      send_box(mk_box(10 + k, k * 4, -k * 2, 200, 200), k == MAX_OBJECTS_DEF);
  endtask

  // clustered sets with random content, some noise boxes and oversize sets
  task automatic test_random_sets(input int box_goal, input bit calm);
    box_t b;
    int   n, cx, cy, spread, size_max, first;
    first = boxes_sent;
    while (boxes_sent - first < box_goal) begin
      if (calm || $urandom_range(3) == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      n        = ($urandom_range(9) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
      cx       = $urandom_range(0, 60000) - 30000;
      cy       = $urandom_range(0, 60000) - 30000;
      spread   = 1 << $urandom_range(3, 12);
      size_max = (spread * 4 > 65535) ? 65535 : spread * 4;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(7) == 0) begin
          b = mk_box($urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
          b = mk_box(($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 3),
                     cx + $urandom_range(0, 2 * spread) - spread,
                     cy + $urandom_range(0, 2 * spread) - spread,
                     $urandom_range(0, size_max), $urandom_range(0, size_max));
        end
        send_box(b, k == n - 1);
      end
    end
  endtask

  initial begin
    failures   = 0;
    boxes_sent = 0;
    held_n     = 0;
    gap_pct    = 25;
    stall_pct  = 25;
    ready_hold = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_box();
    test_directions();
    test_touching_and_equal_tags();
    test_coordinate_extremes();
    test_store_full();
    test_random_sets(300, 1'b0);
    test_random_sets(55, 1'b1);

    // drain: let every expected record arrive, then watch for extras
    in_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### aabb_pair_collision_sweep.f
+incdir+hw/rtl
hw/rtl/aabb_pkg.sv
hw/rtl/aabb_store.sv
hw/rtl/aabb_alu.sv
hw/rtl/aabb_pair_collision_sweep.sv
dv/tb_top.sv
